[rtl/ghts_pkg.sv]
// ----------------------------------------------------------------------------
// ghts_pkg
// shared constants, types and state encodings of the group scaling unit
// ----------------------------------------------------------------------------
package ghts_pkg;

   localparam int NFIELDS     = 4;
   localparam int COLS        = 4;
   localparam int MAX_GROUP   = 1048575;
   localparam int ACTIVE_COLS = (COLS < NFIELDS) ? COLS : NFIELDS;
   localparam int POS_CAP     = (MAX_GROUP < 1048575) ? MAX_GROUP : 1048575;

   localparam int KEY_W  = 32;
   localparam int CNT_W  = 20;
   localparam int VAL_W  = 32;
   localparam int SUM_W  = 48;
   localparam int COL_W  = 2;
   localparam int D_W    = 54;
   localparam int MAG_W  = 53;
   localparam int N_W    = 40;
   localparam int AC_W   = MAG_W + CNT_W;
   localparam int PROD_W = 2 * MAG_W + CNT_W;
   localparam int Q_W    = 62;
   localparam int ROOT_W = 31;
   localparam int SREM_W = ROOT_W + 2;
   localparam int STEP_W = 7;

   typedef logic signed [D_W-1:0]   diff_type;
   typedef logic signed [VAL_W-1:0] value_type;
   typedef logic [CNT_W-1:0]        count_type;
   typedef logic [N_W-1:0]          denom_type;

   typedef enum logic [2:0] {
      T_IDLE,
      T_SETUP,
      T_LOAD,
      T_WAIT,
      T_OUT,
      T_SUM
   } top_state_type;

   typedef enum logic [2:0] {
      SC_IDLE,
      SC_ABS,
      SC_MULC,
      SC_MULM,
      SC_DIV,
      SC_SQRT,
      SC_DONE
   } scl_state_type;

endpackage

[rtl/group_head_tail_scaling_unit.sv]
// ----------------------------------------------------------------------------
// group_head_tail_scaling_unit
// emits tail rows and head rows of sorted groups, scaled per column
// ----------------------------------------------------------------------------
// one item at a time; req_ready is high only while idle
// each scaled column passes through the bit-serial scaler in these steps
// (start, abs, 20 + 53 multiply, 126 divide, 31 square root steps, done)
// an item yields at most a tail and a head row; each result scales 4 columns
// and then waits in the output state while rsp_ready is low
// synchronous active-high reset closes any open group and clears the sums
module group_head_tail_scaling_unit (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [31:0]             req_group_key,
   input  logic [19:0]             req_scale_count,
   input  logic                    req_group_end,
   input  logic signed [31:0]      req_value_0,
   input  logic signed [31:0]      req_value_1,
   input  logic signed [31:0]      req_value_2,
   input  logic signed [31:0]      req_value_3,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_is_head,
   output logic [19:0]             rsp_group_position,
   output logic signed [31:0]      rsp_result_0,
   output logic signed [31:0]      rsp_result_1,
   output logic signed [31:0]      rsp_result_2,
   output logic signed [31:0]      rsp_result_3,
   output logic                    rsp_last_result
);
   import ghts_pkg::*;

   top_state_type           state_ff, state_in;
   logic [KEY_W-1:0]        prev_key_ff, prev_key_in;
   logic                    key_seen_ff, key_seen_in;
   logic signed [SUM_W-1:0] sums_ff [NFIELDS];
   logic signed [SUM_W-1:0] sums_in [NFIELDS];
   logic [CNT_W-1:0]        pos_ff, pos_in;
   logic [CNT_W-1:0]        scale_ff, scale_in;
   value_type               x_ff [NFIELDS];
   value_type               x_in [NFIELDS];
   value_type               res_ff [NFIELDS];
   value_type               res_in [NFIELDS];
   logic                    end_ff, end_in;
   logic                    head_ff, head_in;
   logic [N_W-1:0]          n_ff, n_in;
   logic [COL_W-1:0]        col_ff, col_in;

   logic                    accept;
   logic                    open_grp;
   logic [CNT_W-1:0]        pos_base;
   logic [CNT_W-1:0]        pos_m1;
   logic signed [VAL_W+CNT_W:0] xprod;
   diff_type                d_val;
   logic                    sc_start;
   logic                    sc_done;
   value_type               sc_result;
   logic signed [SUM_W:0]   sum_wide [NFIELDS];

   assign accept   = req_valid && req_ready;
   assign open_grp = !key_seen_ff || (req_group_key != prev_key_ff);
   assign pos_base = open_grp ? '0 : pos_ff;
   assign pos_m1   = pos_ff - 1'b1;
   assign xprod    = (VAL_W+CNT_W+1)'(x_ff[col_ff])
                     * (VAL_W+CNT_W+1)'($signed({1'b0, pos_m1}));
   assign d_val    = head_ff ? D_W'(sums_ff[col_ff])
                             : D_W'(xprod) - D_W'(sums_ff[col_ff]);

   ghts_scaler u_scaler (
      .clock  (clock),
      .reset  (reset),
      .start  (sc_start),
      .d      (d_val),
      .c      (scale_ff),
      .n      (n_ff),
      .done   (sc_done),
      .result (sc_result)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         T_IDLE:  if (accept) state_in = T_SETUP;
         T_SETUP: state_in = (pos_ff >= CNT_W'(2)) ? T_LOAD : T_SUM;
         T_LOAD:  state_in = T_WAIT;
         T_WAIT: begin
            if (sc_done) state_in = (col_ff == COL_W'(ACTIVE_COLS - 1)) ? T_OUT : T_LOAD;
         end
         T_OUT: begin
            if (rsp_ready) state_in = head_ff ? T_IDLE : T_SUM;
         end
         T_SUM:   state_in = end_ff ? T_LOAD : T_IDLE;
         default: state_in = T_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_ready   = (state_ff == T_IDLE);
      rsp_valid   = (state_ff == T_OUT);
      sc_start    = (state_ff == T_LOAD);
      prev_key_in = prev_key_ff;
      key_seen_in = key_seen_ff;
      pos_in      = pos_ff;
      scale_in    = scale_ff;
      end_in      = end_ff;
      head_in     = head_ff;
      n_in        = n_ff;
      col_in      = col_ff;
      for (int k = 0; k < NFIELDS; k++) begin
         sums_in[k]  = sums_ff[k];
         x_in[k]     = x_ff[k];
         res_in[k]   = res_ff[k];
         sum_wide[k] = (SUM_W+1)'(sums_ff[k]) + (SUM_W+1)'(x_ff[k]);
      end
      unique case (state_ff)
         T_IDLE: begin
            if (accept) begin
               if (open_grp) begin
                  scale_in = req_scale_count;
                  for (int k = 0; k < NFIELDS; k++) sums_in[k] = '0;
               end
               prev_key_in = req_group_key;
               // a closing row ends the group right away
               key_seen_in = !req_group_end;
               pos_in      = (pos_base < CNT_W'(POS_CAP)) ? pos_base + 1'b1 : pos_base;
               end_in      = req_group_end;
               x_in[0]     = req_value_0;
               x_in[1]     = req_value_1;
               x_in[2]     = req_value_2;
               x_in[3]     = req_value_3;
            end
         end
         T_SETUP: begin
            head_in = 1'b0;
            n_in    = N_W'(pos_ff) * N_W'(pos_m1);
            col_in  = '0;
            for (int k = 0; k < NFIELDS; k++) res_in[k] = '0;
         end
         T_LOAD: begin
         end
         T_WAIT: begin
            if (sc_done) begin
               res_in[col_ff] = sc_result;
               col_in         = col_ff + 1'b1;
            end
         end
         T_OUT: begin
         end
         T_SUM: begin
            for (int k = 0; k < ACTIVE_COLS; k++) begin
               // saturate to the 48-bit sum range
               if (sum_wide[k][SUM_W] != sum_wide[k][SUM_W-1]) begin
                  sums_in[k] = sum_wide[k][SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                                  : {1'b0, {(SUM_W-1){1'b1}}};
               end else begin
                  sums_in[k] = sum_wide[k][SUM_W-1:0];
               end
            end
            head_in = 1'b1;
            n_in    = N_W'(pos_ff);
            col_in  = '0;
            for (int k = 0; k < NFIELDS; k++) res_in[k] = '0;
         end
         default: begin
         end
      endcase
   end

   assign rsp_is_head        = head_ff;
   assign rsp_group_position = pos_ff;
   assign rsp_result_0       = res_ff[0];
   assign rsp_result_1       = res_ff[1];
   assign rsp_result_2       = res_ff[2];
   assign rsp_result_3       = res_ff[3];
   assign rsp_last_result    = head_ff || !end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= T_IDLE;
         prev_key_ff <= '0;
         key_seen_ff <= 1'b0;
         pos_ff      <= '0;
         scale_ff    <= '0;
         for (int k = 0; k < NFIELDS; k++) sums_ff[k] <= '0;
      end else begin
         state_ff    <= state_in;
         prev_key_ff <= prev_key_in;
         key_seen_ff <= key_seen_in;
         pos_ff      <= pos_in;
         scale_ff    <= scale_in;
         for (int k = 0; k < NFIELDS; k++) sums_ff[k] <= sums_in[k];
      end
      end_ff  <= end_in;
      head_ff <= head_in;
      n_ff    <= n_in;
      col_ff  <= col_in;
      for (int k = 0; k < NFIELDS; k++) begin
         x_ff[k]   <= x_in[k];
         res_ff[k] <= res_in[k];
      end
   end

endmodule

[rtl/ghts_scaler.sv]
// ----------------------------------------------------------------------------
// ghts_scaler
// bit-serial unit: result = sign(d) * floor(sqrt(d*d*c/n)), saturated to 32 bits
// ----------------------------------------------------------------------------
module ghts_scaler (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  ghts_pkg::diff_type  d,
   input  ghts_pkg::count_type c,
   input  ghts_pkg::denom_type n,
   output logic                done,
   output ghts_pkg::value_type result
);
   import ghts_pkg::*;

   scl_state_type       state_ff, state_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   diff_type            d_ff, d_in;
   logic                neg_ff, neg_in;
   logic [MAG_W-1:0]    mag_ff, mag_in;
   logic [CNT_W-1:0]    c_ff, c_in;
   logic [N_W-1:0]      n_ff, n_in;
   logic [PROD_W-1:0]   acc_ff, acc_in;
   logic [AC_W-1:0]     add_ff, add_in;
   logic [N_W-1:0]      rem_ff, rem_in;
   logic [Q_W-1:0]      q_ff, q_in;
   logic                sat_ff, sat_in;
   logic [SREM_W-1:0]   srem_ff, srem_in;
   logic [ROOT_W-1:0]   root_ff, root_in;

   logic [PROD_W-1:0]   acc_next;
   logic [N_W:0]        remsh;
   logic                div_ge;
   logic [SREM_W+1:0]   r2;
   logic [SREM_W+1:0]   trial;
   logic                sq_ge;
   logic [D_W-1:0]      d_abs;
   logic [VAL_W-1:0]    root_ext;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SC_IDLE: if (start) state_in = SC_ABS;
         SC_ABS:  state_in = SC_MULC;
         SC_MULC: if (step_ff == '0) state_in = SC_MULM;
         SC_MULM: if (step_ff == '0) state_in = SC_DIV;
         SC_DIV:  if (step_ff == '0) state_in = SC_SQRT;
         SC_SQRT: if (step_ff == '0) state_in = SC_DONE;
         SC_DONE: state_in = SC_IDLE;
         default: state_in = SC_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      step_in  = step_ff;
      d_in     = d_ff;
      neg_in   = neg_ff;
      mag_in   = mag_ff;
      c_in     = c_ff;
      n_in     = n_ff;
      acc_in   = acc_ff;
      add_in   = add_ff;
      rem_in   = rem_ff;
      q_in     = q_ff;
      sat_in   = sat_ff;
      srem_in  = srem_ff;
      root_in  = root_ff;
      acc_next = '0;
      remsh    = {rem_ff, acc_ff[PROD_W-1]};
      div_ge   = remsh >= {1'b0, n_ff};
      r2       = {srem_ff, q_ff[Q_W-1:Q_W-2]};
      trial    = {2'b00, root_ff, 2'b01};
      sq_ge    = r2 >= trial;
      d_abs    = d_ff[D_W-1] ? (D_W'(0) - d_ff) : d_ff;
      unique case (state_ff)
         SC_IDLE: begin
            if (start) begin
               d_in = d;
               c_in = c;
               n_in = n;
            end
         end
         SC_ABS: begin
            neg_in  = d_ff[D_W-1];
            mag_in  = d_abs[MAG_W-1:0];
            acc_in  = '0;
            step_in = STEP_W'(CNT_W - 1);
         end
         SC_MULC: begin
            // mag * c, multiplier bits msb first
            acc_next = {acc_ff[PROD_W-2:0], 1'b0}
                       + (c_ff[CNT_W-1] ? PROD_W'(mag_ff) : '0);
            c_in    = {c_ff[CNT_W-2:0], 1'b0};
            acc_in  = acc_next;
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               add_in  = acc_next[AC_W-1:0];
               acc_in  = '0;
               step_in = STEP_W'(MAG_W - 1);
            end
         end
         SC_MULM: begin
            acc_in  = {acc_ff[PROD_W-2:0], 1'b0}
                      + (mag_ff[MAG_W-1] ? PROD_W'(add_ff) : '0);
            mag_in  = {mag_ff[MAG_W-2:0], 1'b0};
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               step_in = STEP_W'(PROD_W - 1);
               rem_in  = '0;
               q_in    = '0;
               sat_in  = 1'b0;
            end
         end
         SC_DIV: begin
            // restoring division, quotient bits past 2^62 only mark saturation
            rem_in  = div_ge ? N_W'(remsh - {1'b0, n_ff}) : remsh[N_W-1:0];
            q_in    = {q_ff[Q_W-2:0], div_ge};
            sat_in  = sat_ff | q_ff[Q_W-1];
            acc_in  = {acc_ff[PROD_W-2:0], 1'b0};
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               step_in = STEP_W'(ROOT_W - 1);
               srem_in = '0;
               root_in = '0;
            end
         end
         SC_SQRT: begin
            srem_in = sq_ge ? SREM_W'(r2 - trial) : r2[SREM_W-1:0];
            root_in = {root_ff[ROOT_W-2:0], sq_ge};
            q_in    = {q_ff[Q_W-3:0], 2'b00};
            step_in = step_ff - 1'b1;
         end
         SC_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // outputs
   always_comb begin
      done     = (state_ff == SC_DONE);
      root_ext = {1'b0, root_ff};
      if (neg_ff) begin
         result = sat_ff ? value_type'({1'b1, {(VAL_W-1){1'b0}}})
                         : value_type'(VAL_W'(0) - root_ext);
      end else begin
         result = sat_ff ? value_type'({1'b0, {(VAL_W-1){1'b1}}})
                         : value_type'(root_ext);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SC_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
      d_ff    <= d_in;
      neg_ff  <= neg_in;
      mag_ff  <= mag_in;
      c_ff    <= c_in;
      n_ff    <= n_in;
      acc_ff  <= acc_in;
      add_ff  <= add_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      sat_ff  <= sat_in;
      srem_ff <= srem_in;
      root_ff <= root_in;
   end

endmodule

[rtl/ghts_checker.sv]
// ----------------------------------------------------------------------------
// ghts_checker
// port-level checks of the group scaling unit
// ----------------------------------------------------------------------------
module ghts_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_is_head,
   input logic [19:0] rsp_group_position,
   input logic        rsp_last_result
);

   // a pending result holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before it was taken");

   // no new item while a result is pending
   a_busy_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input ready while a result is pending");

   // an accepted item keeps the unit busy next cycle
   a_busy_acc: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input ready right after an item");

   // head row always closes the item
   a_head_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_head |-> rsp_last_result)
      else $error("head row not marked last");

   // tail rows only from position two on
   a_tail_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_head |-> (rsp_group_position != 20'd0) && (rsp_group_position != 20'd1))
      else $error("tail row at position below two");

endmodule

bind group_head_tail_scaling_unit ghts_checker u_ghts_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_is_head        (rsp_is_head),
   .rsp_group_position (rsp_group_position),
   .rsp_last_result    (rsp_last_result)
);

[tb/group_head_tail_scaling_unit_tb.sv]
// ----------------------------------------------------------------------------
// group_head_tail_scaling_unit_tb
// drives keyed rows with random gaps and compares every emitted tail and head
// row with a built-in model or table; receiver stalls randomly, once for long
// ----------------------------------------------------------------------------
module group_head_tail_scaling_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ghts_pkg::*;

   localparam int  NUM_ITEMS   = 900;
   localparam int  DRAIN_WAIT  = 2500;
   localparam int  LONG_HOLD   = 4000;
   localparam longint CYCLE_LIMIT = 12_000_000;
   localparam longint SUM_HI   = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint SUM_LO   = -SUM_HI - 1;

   typedef struct {
      logic [31:0] key;
      logic [19:0] cnt;
      logic        fin;
      value_type   v [4];
   } row_t;

   typedef struct {
      logic        head;
      logic [19:0] pos;
      value_type   r [4];
      logic        last;
   } scaled_row_t;

   typedef struct {
      row_t        row;
      logic        typed;
      scaled_row_t res;
   } directed_row_t;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [31:0] req_group_key = '0;
   logic [19:0] req_scale_count = '0;
   logic req_group_end = 0;
   value_type req_value_0 = '0, req_value_1 = '0, req_value_2 = '0, req_value_3 = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic rsp_is_head;
   logic [19:0] rsp_group_position;
   value_type rsp_result_0, rsp_result_1, rsp_result_2, rsp_result_3;
   logic rsp_last_result;

   group_head_tail_scaling_unit i_dut (.*);

   // model state
   logic [31:0] open_key;
   logic        group_open;
   longint      col_sum [4];
   int unsigned row_pos;
   longint unsigned grp_scale;

   scaled_row_t pending_rows[$];
   int     errors = 0;
   longint cycles = 0;
   bit     hold_req = 0;
   int     sent = 0;

   initial forever #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   function automatic longint unsigned int_sqrt(longint unsigned t);
      longint unsigned res = 0;
      longint unsigned b = 64'd1 << 62;
      while (b > t) b >>= 2;
      while (b != 0) begin
         if (t >= res + b) begin
            t -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   // d * sqrt(c / n), magnitude truncated, saturated to 32 bits
   function automatic value_type scale_col(longint d, longint unsigned c, longint unsigned n);
      logic [127:0] mag, sq, qa, ra, t, lim;
      longint unsigned m;
      bit sat;
      mag = d < 0 ? 128'(-d) : 128'(d);
      lim = 128'd1 << 62;
      sat = 0;
      if (c == 0 || n == 0 || mag == 0) return '0;
      sq = mag * mag;
      qa = sq / n;
      ra = sq % n;
      if (qa >= lim || qa > (lim - 1) / c) begin
         sat = 1;
      end else begin
         t = qa * c + (ra * c) / n;
         if (t >= lim) sat = 1;
      end
      m = sat ? (64'd1 << 31) : int_sqrt(t[63:0]);
      if (d < 0) return value_type'(-longint'(m));
      return m > 64'h7FFF_FFFF ? 32'sh7FFF_FFFF : value_type'(m);
   endfunction

   function automatic void clear_model();
      open_key = '0;
      group_open = 0;
      row_pos = 0;
      grp_scale = 0;
      foreach (col_sum[k]) col_sum[k] = 0;
   endfunction

   // returns number of rows predicted; queues them only when keep is set
   function automatic int predict_rows(row_t x, bit keep);
      scaled_row_t o;
      longint s;
      longint unsigned i;
      int n = 0;
      if (!group_open || x.key != open_key) begin
         foreach (col_sum[k]) col_sum[k] = 0;
         row_pos = 0;
         grp_scale = x.cnt;
         open_key = x.key;
         group_open = 1;
      end
      if (row_pos < POS_CAP) row_pos++;
      i = row_pos;
      if (i >= 2) begin
         o.head = 0;
         o.pos = 20'(i);
         for (int k = 0; k < 4; k++)
            o.r[k] = k < ACTIVE_COLS ? scale_col(longint'(x.v[k]) * longint'(i - 1)
                                       - col_sum[k], grp_scale, i * (i - 1)) : '0;
         o.last = !x.fin;
         if (keep) pending_rows.insert(pending_rows.size(), o);
         n++;
      end
      for (int k = 0; k < ACTIVE_COLS; k++) begin
         s = col_sum[k] + longint'(x.v[k]);
         col_sum[k] = s > SUM_HI ? SUM_HI : (s < SUM_LO ? SUM_LO : s);
      end
      if (x.fin) begin
         o.head = 1;
         o.pos = 20'(i);
         for (int k = 0; k < 4; k++)
            o.r[k] = k < ACTIVE_COLS ? scale_col(col_sum[k], grp_scale, i) : '0;
         o.last = 1;
         if (keep) pending_rows.insert(pending_rows.size(), o);
         n++;
         group_open = 0;
      end
      return n;
   endfunction

   task automatic send_row(row_t x);
      req_valid <= 1;
      req_group_key <= x.key;
      req_scale_count <= x.cnt;
      req_group_end <= x.fin;
      req_value_0 <= x.v[0];
      req_value_1 <= x.v[1];
      req_value_2 <= x.v[2];
      req_value_3 <= x.v[3];
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      sent++;
   endtask

   task automatic idle_gap();
      int g;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: g = 0;
         5, 6, 7: g = $urandom_range(1, 4);
         8: g = $urandom_range(5, 20);
         default: g = $urandom_range(50, 300);
      endcase
      if (g > 0) begin
         req_valid <= 0;
         repeat (g) @(posedge clock);
      end
   endtask

   function automatic value_type rand_value();
      case ($urandom_range(0, 7))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return '0;
         3, 4: return value_type'($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
         default: return value_type'($urandom);
      endcase
   endfunction

   function automatic logic [19:0] rand_count();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return 20'hF_FFFF;
         2, 3, 4: return 20'($urandom_range(1, 16));
         default: return 20'($urandom_range(1, 20'hF_FFFF));
      endcase
   endfunction

   function automatic row_t make_row(logic [31:0] key, logic [19:0] cnt, logic fin);
      row_t x;
      x.key = key;
      x.cnt = cnt;
      x.fin = fin;
      foreach (x.v[k]) x.v[k] = rand_value();
      return x;
   endfunction

   task automatic report(string what, longint e, longint a);
      errors++;
      $display("%0t: mismatch %s expected %0d actual %0d", $time, what, e, a);
   endtask

   // results are taken at negedge; the item moves at the following posedge
   always @(negedge clock) begin
      scaled_row_t e;
      value_type got [4];
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_result_0, rsp_result_1, rsp_result_2, rsp_result_3};
         if (pending_rows.size() == 0) begin
            report("unexpected item, position", 0, rsp_group_position);
         end else begin
            e = pending_rows.pop_front();
            if (rsp_is_head !== e.head) report("is_head", e.head, rsp_is_head);
            if (rsp_group_position !== e.pos)
               report("group_position", e.pos, rsp_group_position);
            for (int k = 0; k < 4; k++)
               if (got[k] !== e.r[k]) report($sformatf("result_%0d", k), e.r[k], got[k]);
            if (rsp_last_result !== e.last) report("last_result", e.last, rsp_last_result);
         end
      end
   end

   // receiver: random ready runs, one long hold-off on request
   initial begin
      int len;
      bit v;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_req) begin
            hold_req = 0;
            rsp_ready <= 0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            v = $urandom_range(0, 9) < 7;
            len = $urandom_range(0, 15) == 0 ? $urandom_range(30, 200) : $urandom_range(1, 4);
            if ($urandom_range(0, 7) == 0) begin
               v = 1;
               len = $urandom_range(100, 400);
            end
            rsp_ready <= v;
            repeat (len) @(posedge clock);
         end
      end
   end

   initial begin
      directed_row_t dir_rows [] = '{
         '{'{32'd5, 20'd1, 1'b1, '{32'sd65536, 32'sd0, -32'sd65536, 32'sh7FFF_FFFF}},
           1'b1, '{1'b1, 20'd1, '{32'sd65536, 32'sd0, -32'sd65536, 32'sh7FFF_FFFF}, 1'b1}},
         '{'{32'd5, 20'd0, 1'b1, '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd1, -32'sd1}},
           1'b1, '{1'b1, 20'd1, '{32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b1}},
         '{'{32'd7, 20'd4, 1'b0, '{32'sd65536, 32'sd131072, -32'sd65536, 32'sd0}}, 1'b0, '{default:'0}},
         '{'{32'd7, 20'd4, 1'b0, '{32'sd0, 32'sd65536, 32'sd65536, 32'sd7}}, 1'b0, '{default:'0}},
         '{'{32'd7, 20'd4, 1'b1, '{-32'sd65536, 32'sd1, 32'sd0, 32'sh8000_0000}}, 1'b0, '{default:'0}},
         '{'{32'd0, 20'hF_FFFF, 1'b0, '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
           32'sh7FFF_FFFF}}, 1'b0, '{default:'0}},
         '{'{32'd0, 20'hF_FFFF, 1'b0, '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
           32'sh8000_0000}}, 1'b0, '{default:'0}},
         '{'{32'd0, 20'hF_FFFF, 1'b1, '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, -32'sd1}},
           1'b0, '{default:'0}},
         '{'{32'hFFFF_FFFF, 20'd3, 1'b0, '{32'sh8000_0000, 32'sd12345, -32'sd99, 32'sd1}},
           1'b0, '{default:'0}},
         '{'{32'hFFFF_FFFF, 20'd3, 1'b0, '{32'sd0, 32'sd0, 32'sd0, 32'sd0}}, 1'b0, '{default:'0}},
         // key change without an end flag drops the open group
         '{'{32'd1, 20'd2, 1'b0, '{32'sd3, -32'sd3, 32'sd300000, 32'sd65536}}, 1'b0, '{default:'0}},
         '{'{32'd1, 20'd2, 1'b1, '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd5, -32'sd5}},
           1'b0, '{default:'0}},
         '{'{32'hA5A5_A5A5, 20'd1, 1'b1, '{32'sd0, 32'sd0, 32'sd0, 32'sd0}},
           1'b1, '{1'b1, 20'd1, '{32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b1}},
         '{'{32'd2, 20'h8_0000, 1'b0, '{32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0F0F_0F0F,
           32'shF0F0_F0F0}}, 1'b0, '{default:'0}},
         '{'{32'd2, 20'h8_0000, 1'b0, '{32'shAAAA_AAAA, 32'sh5555_5555, 32'shF0F0_F0F0,
           32'sh0F0F_0F0F}}, 1'b0, '{default:'0}},
         '{'{32'd2, 20'h8_0000, 1'b1, '{-32'sd1, -32'sd1, -32'sd1, -32'sd1}}, 1'b0, '{default:'0}}
      };
      logic [31:0] key;
      logic [19:0] cnt;
      int len, n;
      bit broken, paused;
      row_t x;

      clear_model();
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (dir_rows[j]) begin
         n = predict_rows(dir_rows[j].row, !dir_rows[j].typed);
         if (dir_rows[j].typed) pending_rows.insert(pending_rows.size(), dir_rows[j].res);
         send_row(dir_rows[j].row);
         idle_gap();
      end

      // block fills while the receiver holds off
      hold_req = 1;
      key = $urandom;
      paused = 0;
      while (sent < NUM_ITEMS) begin
         if (!paused && sent >= NUM_ITEMS / 2) begin
            paused = 1;
            req_valid <= 0;
            wait (pending_rows.size() == 0);
            @(posedge clock);
         end
         if ($urandom_range(0, 9) == 0) begin
            // noise row
            x = make_row($urandom_range(0, 3) == 0 ? key : $urandom, rand_count(),
                         $urandom_range(0, 1));
            n = predict_rows(x, 1);
            send_row(x);
            idle_gap();
         end else begin
            case ($urandom_range(0, 5))
               0: key = $urandom;
               1: key = key;
               default: key = key + $urandom_range(1, 3);
            endcase
            cnt = rand_count();
            len = $urandom_range(0, 9) == 0 ? $urandom_range(7, 20) : $urandom_range(1, 6);
            broken = $urandom_range(0, 9) == 0;
            for (int r = 0; r < len; r++) begin
               x = make_row(key, $urandom_range(0, 3) == 0 ? rand_count() : cnt,
                            r == len - 1 && !broken);
               n = predict_rows(x, 1);
               send_row(x);
               idle_gap();
            end
         end
      end
      req_valid <= 0;

      wait (pending_rows.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (errors == 0 && pending_rows.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

[group_head_tail_scaling_unit.f]
rtl/ghts_pkg.sv
rtl/ghts_scaler.sv
rtl/group_head_tail_scaling_unit.sv
rtl/ghts_checker.sv
tb/group_head_tail_scaling_unit_tb.sv
